// ===== rtl/hrsp_pkg.sv =====
package hrsp_pkg;

    localparam int VERSION_BITS = 10;

    typedef enum logic [4:0] {
        PH_METHOD_FIRST = 5'd0,
        PH_METHOD_P     = 5'd1,
        PH_METHOD_REST  = 5'd2,
        PH_URI_WS       = 5'd3,
        PH_PATH         = 5'd4,
        PH_QKEY         = 5'd5,
        PH_QVAL         = 5'd6,
        PH_VER_WS       = 5'd7,
        PH_VER_LIT      = 5'd8,
        PH_MAJOR        = 5'd9,
        PH_MINOR        = 5'd10,
        PH_REQ_LF       = 5'd11,
        PH_HDR_START    = 5'd12,
        PH_HDR_NAME     = 5'd13,
        PH_HDR_COLONWS  = 5'd14,
        PH_HDR_VALSP    = 5'd15,
        PH_HDR_VAL      = 5'd16,
        PH_HDR_LF       = 5'd17,
        PH_FINAL_LF     = 5'd18,
        PH_ACCEPT       = 5'd19,
        PH_ERROR        = 5'd20
    } t_phase;

    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_PATH  = 3'd1;
    localparam logic [2:0] CLS_QKEY  = 3'd2;
    localparam logic [2:0] CLS_QVAL  = 3'd3;
    localparam logic [2:0] CLS_HNAME = 3'd4;
    localparam logic [2:0] CLS_HVAL  = 3'd5;

    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [1:0] PCT_IDLE = 2'd0;
    localparam logic [1:0] PCT_HIGH = 2'd1;
    localparam logic [1:0] PCT_LOW  = 2'd2;

    typedef struct packed {
        logic [2:0] token_class;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_start;
        logic       token_end;
        logic [2:0] method_code;
        logic [9:0] version_major;
        logic [9:0] version_minor;
        logic [1:0] parse_status;
    } t_result;

    // Method text, indexed by candidate and character position.
    function automatic logic [7:0] method_char(input logic [2:0] m, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (m)
            3'd0: case (p) 3'd0: c = "H"; 3'd1: c = "E"; 3'd2: c = "A"; 3'd3: c = "D";
                default: c = 8'h00; endcase
            3'd1: case (p) 3'd0: c = "G"; 3'd1: c = "E"; 3'd2: c = "T";
                default: c = 8'h00; endcase
            3'd2: case (p) 3'd0: c = "P"; 3'd1: c = "O"; 3'd2: c = "S"; 3'd3: c = "T";
                default: c = 8'h00; endcase
            3'd3: case (p) 3'd0: c = "P"; 3'd1: c = "U"; 3'd2: c = "T";
                default: c = 8'h00; endcase
            3'd4: case (p) 3'd0: c = "D"; 3'd1: c = "E"; 3'd2: c = "L"; 3'd3: c = "E";
                3'd4: c = "T"; 3'd5: c = "E"; default: c = 8'h00; endcase
            3'd5: case (p) 3'd0: c = "O"; 3'd1: c = "P"; 3'd2: c = "T"; 3'd3: c = "I";
                3'd4: c = "O"; 3'd5: c = "N"; 3'd6: c = "S"; default: c = 8'h00; endcase
            3'd6: case (p) 3'd0: c = "T"; 3'd1: c = "R"; 3'd2: c = "A"; 3'd3: c = "C";
                3'd4: c = "E"; default: c = 8'h00; endcase
            3'd7: case (p) 3'd0: c = "C"; 3'd1: c = "O"; 3'd2: c = "N"; 3'd3: c = "N";
                3'd4: c = "E"; 3'd5: c = "C"; 3'd6: c = "T"; default: c = 8'h00; endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] method_len(input logic [2:0] m);
        logic [2:0] n;
        case (m)
            3'd0: n = 3'd4;
            3'd1: n = 3'd3;
            3'd2: n = 3'd4;
            3'd3: n = 3'd3;
            3'd4: n = 3'd6;
            3'd5: n = 3'd7;
            3'd6: n = 3'd5;
            default: n = 3'd7;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] version_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0: c = "H";
            3'd1: c = "T";
            3'd2: c = "T";
            3'd3: c = "P";
            3'd4: c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// ===== rtl/http_request_stream_parser_unit.sv =====
// Channel | Direction | Handshake            | Payload
// input   | in        | i_valid / o_ready    | i_data_byte, i_end_of_input
// result  | out       | o_valid / i_ready    | o_token_class .. o_parse_status
//
// Each accepted input transaction yields exactly one result transaction.
// The parser state is updated in the cycle of acceptance; the result is held in
// an output register and a single skid register, so one transaction per cycle
// is sustained while i_ready is high; a result waits in the skid register only on a stall.
// Reset (synchronous, active low) returns the parser to the method start.
// A stall on the result side is absorbed by the skid register before o_ready drops.
module http_request_stream_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_token_class,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_token_start,
    output logic       o_token_end,
    output logic [2:0] o_method_code,
    output logic [9:0] o_version_major,
    output logic [9:0] o_version_minor,
    output logic [1:0] o_parse_status
);

    localparam int VB = hrsp_pkg::VERSION_BITS;
    localparam logic [VB-1:0] CAP = {VB{1'b1}};

    hrsp_pkg::t_phase r_phase, n_phase;
    logic [2:0]    r_cand, n_cand;
    logic [2:0]    r_pos, n_pos;
    logic [1:0]    r_pct, n_pct;
    logic [3:0]    r_nib, n_nib;
    logic [VB-1:0] r_major, n_major;
    logic [VB-1:0] r_minor, n_minor;
    logic          r_digits, n_digits;
    logic          r_open, n_open;

    hrsp_pkg::t_result r_out, r_skid, res;
    logic r_out_v, r_skid_v;

    logic take;
    assign o_ready = !r_skid_v;
    assign take    = i_valid && o_ready;

    // Byte decoding helpers.
    logic [7:0] c;
    logic       is_dig, hex_ok;
    logic [3:0] hex_v;
    logic [VB+3:0] acc_in, acc_mul;
    logic [VB-1:0] acc_sat;
    logic [3:0] dig;

    assign c      = i_data_byte;
    assign is_dig = (c >= "0") && (c <= "9");
    assign dig    = c[3:0];

    always_comb begin
        hex_ok = 1'b1;
        hex_v  = 4'd0;
        if (is_dig) begin
            hex_v = c[3:0];
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            hex_v = 4'(c[3:0] + 4'd9);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // One shared multiply-by-ten and saturate for whichever version field is active.
    // The running value never exceeds the cap, so (cap*10+9) fits in VB+4 bits.
    assign acc_in  = (r_phase == hrsp_pkg::PH_MAJOR) ? (VB+4)'(r_major) : (VB+4)'(r_minor);
    assign acc_mul = (acc_in << 3) + (acc_in << 1) + (VB+4)'(dig);
    assign acc_sat = (acc_mul > (VB+4)'(CAP)) ? CAP : acc_mul[VB-1:0];

    // Next-state and per-byte result.
    always_comb begin
        logic fail, emit, close_tok, qdelim;
        logic [2:0] emit_cls, close_cls, qcls;
        logic [7:0] emit_b;
        hrsp_pkg::t_phase qnext;

        n_phase = r_phase; n_cand = r_cand; n_pos = r_pos; n_pct = r_pct;
        n_nib = r_nib; n_major = r_major; n_minor = r_minor;
        n_digits = r_digits; n_open = r_open;
        fail = 1'b0; emit = 1'b0; close_tok = 1'b0; qdelim = 1'b0;
        emit_cls = hrsp_pkg::CLS_NONE; close_cls = hrsp_pkg::CLS_NONE;
        emit_b = c;
        qnext = hrsp_pkg::PH_QKEY;
        qcls = (r_phase == hrsp_pkg::PH_QKEY) ? hrsp_pkg::CLS_QKEY : hrsp_pkg::CLS_QVAL;
        res = '0;

        if (r_phase != hrsp_pkg::PH_ACCEPT && r_phase != hrsp_pkg::PH_ERROR) begin
            if (i_end_of_input) begin
                fail = 1'b1;
            end else begin
                case (r_phase)
                    hrsp_pkg::PH_METHOD_FIRST: begin
                        n_pos = 3'd1;
                        n_phase = hrsp_pkg::PH_METHOD_REST;
                        case (c)
                            "H": n_cand = 3'd0;
                            "G": n_cand = 3'd1;
                            "P": n_phase = hrsp_pkg::PH_METHOD_P;
                            "D": n_cand = 3'd4;
                            "O": n_cand = 3'd5;
                            "T": n_cand = 3'd6;
                            "C": n_cand = 3'd7;
                            default: fail = 1'b1;
                        endcase
                    end
                    hrsp_pkg::PH_METHOD_P: begin
                        if (c == "O") begin
                            n_cand = 3'd2; n_pos = 3'd2; n_phase = hrsp_pkg::PH_METHOD_REST;
                        end else if (c == "U") begin
                            n_cand = 3'd3; n_pos = 3'd2; n_phase = hrsp_pkg::PH_METHOD_REST;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    hrsp_pkg::PH_METHOD_REST: begin
                        if (c != hrsp_pkg::method_char(r_cand, r_pos)) begin
                            fail = 1'b1;
                        end else begin
                            n_pos = r_pos + 3'd1;
                            if (n_pos >= hrsp_pkg::method_len(r_cand)) begin
                                n_phase = hrsp_pkg::PH_URI_WS;
                            end
                        end
                    end
                    hrsp_pkg::PH_URI_WS: begin
                        if (hrsp_pkg::is_ws(c)) begin
                            n_phase = r_phase;
                        end else if (c == "?") begin
                            n_phase = hrsp_pkg::PH_QKEY;
                        end else if (c == 8'h00) begin
                            fail = 1'b1;
                        end else begin
                            n_phase = hrsp_pkg::PH_PATH;
                            emit = 1'b1; emit_cls = hrsp_pkg::CLS_PATH;
                        end
                    end
                    hrsp_pkg::PH_PATH: begin
                        if (c == "?" || c == " ") begin
                            close_tok = 1'b1; close_cls = hrsp_pkg::CLS_PATH;
                            n_phase = (c == "?") ? hrsp_pkg::PH_QKEY : hrsp_pkg::PH_VER_WS;
                        end else if (c == 8'h00) begin
                            fail = 1'b1;
                        end else begin
                            emit = 1'b1; emit_cls = hrsp_pkg::CLS_PATH;
                        end
                    end
                    hrsp_pkg::PH_QKEY, hrsp_pkg::PH_QVAL: begin
                        if (c == "&") begin
                            qdelim = 1'b1; qnext = hrsp_pkg::PH_QKEY;
                        end else if (c == " ") begin
                            qdelim = 1'b1; qnext = hrsp_pkg::PH_VER_WS;
                        end else if (c == "=" && r_phase == hrsp_pkg::PH_QKEY) begin
                            qdelim = 1'b1; qnext = hrsp_pkg::PH_QVAL;
                        end
                        if (qdelim) begin
                            close_tok = 1'b1; close_cls = qcls; n_phase = qnext;
                        end else if (c == 8'h00) begin
                            fail = 1'b1;
                        end else if (r_pct == hrsp_pkg::PCT_IDLE) begin
                            if (c == "%") begin
                                n_pct = hrsp_pkg::PCT_HIGH;
                            end else begin
                                emit = 1'b1; emit_cls = qcls;
                            end
                        end else if (!hex_ok) begin
                            fail = 1'b1;
                        end else if (r_pct == hrsp_pkg::PCT_HIGH) begin
                            n_nib = hex_v; n_pct = hrsp_pkg::PCT_LOW;
                        end else begin
                            emit = 1'b1; emit_cls = qcls; emit_b = {r_nib, hex_v};
                            n_pct = hrsp_pkg::PCT_IDLE;
                        end
                    end
                    hrsp_pkg::PH_VER_WS: begin
                        if (!hrsp_pkg::is_ws(c)) begin
                            if (c != "H") begin
                                fail = 1'b1;
                            end else begin
                                n_pos = 3'd1; n_phase = hrsp_pkg::PH_VER_LIT;
                            end
                        end
                    end
                    hrsp_pkg::PH_VER_LIT: begin
                        if (c != hrsp_pkg::version_char(r_pos)) begin
                            fail = 1'b1;
                        end else begin
                            n_pos = r_pos + 3'd1;
                            if (n_pos >= 3'd5) begin
                                n_phase = hrsp_pkg::PH_MAJOR; n_digits = 1'b0;
                            end
                        end
                    end
                    hrsp_pkg::PH_MAJOR: begin
                        if (is_dig) begin
                            n_major = acc_sat; n_digits = 1'b1;
                        end else if (c == "." && r_digits) begin
                            n_phase = hrsp_pkg::PH_MINOR; n_digits = 1'b0;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    hrsp_pkg::PH_MINOR: begin
                        if (is_dig) begin
                            n_minor = acc_sat; n_digits = 1'b1;
                        end else if (c == 8'h0D && r_digits) begin
                            n_phase = hrsp_pkg::PH_REQ_LF;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    hrsp_pkg::PH_REQ_LF, hrsp_pkg::PH_HDR_LF: begin
                        if (c == 8'h0A) n_phase = hrsp_pkg::PH_HDR_START;
                        else fail = 1'b1;
                    end
                    hrsp_pkg::PH_HDR_START: begin
                        if (c == 8'h0D) begin
                            n_phase = hrsp_pkg::PH_FINAL_LF;
                        end else if (c == ":" || c == " " || c == 8'h00) begin
                            fail = 1'b1;
                        end else begin
                            n_phase = hrsp_pkg::PH_HDR_NAME;
                            emit = 1'b1; emit_cls = hrsp_pkg::CLS_HNAME;
                        end
                    end
                    hrsp_pkg::PH_HDR_NAME: begin
                        if (c == ":") begin
                            close_tok = 1'b1; close_cls = hrsp_pkg::CLS_HNAME;
                            n_phase = hrsp_pkg::PH_HDR_VALSP;
                        end else if (c == " " || c == 8'h0D) begin
                            close_tok = 1'b1; close_cls = hrsp_pkg::CLS_HNAME;
                            n_phase = hrsp_pkg::PH_HDR_COLONWS;
                        end else if (c == 8'h00) begin
                            fail = 1'b1;
                        end else begin
                            emit = 1'b1; emit_cls = hrsp_pkg::CLS_HNAME;
                        end
                    end
                    hrsp_pkg::PH_HDR_COLONWS: begin
                        if (c == ":") n_phase = hrsp_pkg::PH_HDR_VALSP;
                        else if (!hrsp_pkg::is_ws(c)) fail = 1'b1;
                    end
                    hrsp_pkg::PH_HDR_VALSP: begin
                        if (c == 8'h0D) begin
                            n_phase = hrsp_pkg::PH_HDR_LF;
                        end else if (c == 8'h00) begin
                            fail = 1'b1;
                        end else if (c != " ") begin
                            n_phase = hrsp_pkg::PH_HDR_VAL;
                            emit = 1'b1; emit_cls = hrsp_pkg::CLS_HVAL;
                        end
                    end
                    hrsp_pkg::PH_HDR_VAL: begin
                        if (c == 8'h0D) begin
                            close_tok = 1'b1; close_cls = hrsp_pkg::CLS_HVAL;
                            n_phase = hrsp_pkg::PH_HDR_LF;
                        end else if (c == 8'h00) begin
                            fail = 1'b1;
                        end else begin
                            emit = 1'b1; emit_cls = hrsp_pkg::CLS_HVAL;
                        end
                    end
                    hrsp_pkg::PH_FINAL_LF: begin
                        if (c == 8'h0A) n_phase = hrsp_pkg::PH_ACCEPT;
                        else fail = 1'b1;
                    end
                    default: fail = 1'b1;
                endcase
            end
        end

        // An escape left open at a delimiter is an error.
        if (close_tok && r_pct != hrsp_pkg::PCT_IDLE) fail = 1'b1;

        if (!fail && emit) begin
            res.token_class = emit_cls;
            res.out_byte    = emit_b;
            res.byte_valid  = 1'b1;
            res.token_start = !r_open;
            n_open = 1'b1;
        end
        if (!fail && close_tok) begin
            if (r_open) begin
                res.token_end   = 1'b1;
                res.token_class = close_cls;
            end
            n_open = 1'b0;
        end
        if (fail) begin
            n_phase = hrsp_pkg::PH_ERROR;
            // State other than the phase keeps only what the model committed before failing.
            n_open = r_open;
            n_pct  = r_pct;
        end

        res.method_code   = n_cand;
        res.version_major = 10'(n_major);
        res.version_minor = 10'(n_minor);
        res.parse_status  = (n_phase == hrsp_pkg::PH_ACCEPT) ? hrsp_pkg::ST_ACCEPT :
                            (n_phase == hrsp_pkg::PH_ERROR)  ? hrsp_pkg::ST_ERROR :
                                                               hrsp_pkg::ST_BUSY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hrsp_pkg::PH_METHOD_FIRST;
            r_cand   <= '0;
            r_pos    <= '0;
            r_pct    <= hrsp_pkg::PCT_IDLE;
            r_nib    <= '0;
            r_major  <= '0;
            r_minor  <= '0;
            r_digits <= 1'b0;
            r_open   <= 1'b0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_cand   <= n_cand;
            r_pos    <= n_pos;
            r_pct    <= n_pct;
            r_nib    <= n_nib;
            r_major  <= n_major;
            r_minor  <= n_minor;
            r_digits <= n_digits;
            r_open   <= n_open;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || i_ready) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= take;
                end
            end else if (take) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_ready) begin
            r_out <= r_skid_v ? r_skid : res;
        end
        if (take && r_out_v && !i_ready) begin
            r_skid <= res;
        end
    end

    assign o_valid         = r_out_v;
    assign o_token_class   = r_out.token_class;
    assign o_out_byte      = r_out.out_byte;
    assign o_byte_valid    = r_out.byte_valid;
    assign o_token_start   = r_out.token_start;
    assign o_token_end     = r_out.token_end;
    assign o_method_code   = r_out.method_code;
    assign o_version_major = r_out.version_major;
    assign o_version_minor = r_out.version_minor;
    assign o_parse_status  = r_out.parse_status;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid full while output empty");
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hrsp_pkg::PH_ERROR) |=> (r_phase == hrsp_pkg::PH_ERROR))
        else $error("error phase left");
    a_no_byte_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parse_status == hrsp_pkg::ST_ERROR) |-> !o_byte_valid && !o_token_end)
        else $error("token output with error status");
    a_pct_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pct != hrsp_pkg::PCT_IDLE) |-> (r_phase == hrsp_pkg::PH_QKEY ||
        r_phase == hrsp_pkg::PH_QVAL || r_phase == hrsp_pkg::PH_ERROR))
        else $error("escape pending outside query");
`endif

endmodule

// ===== dv/http_request_stream_parser_unit_tb.sv =====
module http_request_stream_parser_unit_tb;

    // Clock, reset and the two channels of the parser.
    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       i_end_of_input;
    logic       o_valid;
    logic       i_ready;
    logic [2:0] o_token_class;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_token_start;
    logic       o_token_end;
    logic [2:0] o_method_code;
    logic [9:0] o_version_major;
    logic [9:0] o_version_minor;
    logic [1:0] o_parse_status;

    http_request_stream_parser_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_class  (o_token_class),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_token_start  (o_token_start),
        .o_token_end    (o_token_end),
        .o_method_code  (o_method_code),
        .o_version_major(o_version_major),
        .o_version_minor(o_version_minor),
        .o_parse_status (o_parse_status)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // One pending result transaction. Directed rows also carry a status that
    // was typed in by hand, which is checked against the block directly.
    typedef struct {
        hrsp_pkg::t_result res;
        bit                typed;
        logic [1:0]        typed_status;
    } t_pending;

    t_pending pending_results[$];
    int       error_count;
    int       results_seen;
    bit       stim_done;

    // ---------------------------------------------------------------------
    // Parser shadow state. It mirrors the block's own state and is advanced
    // once per accepted input transaction.
    // ---------------------------------------------------------------------
    hrsp_pkg::t_phase  sh_phase;
    logic [2:0]        sh_cand;
    logic [2:0]        sh_pos;
    logic [1:0]        sh_pct;
    logic [3:0]        sh_nibble;
    int unsigned       sh_major;
    int unsigned       sh_minor;
    bit                sh_digits;
    bit                sh_open;
    hrsp_pkg::t_result sh_out;

    string method_names [8] = '{"HEAD", "GET", "POST", "PUT", "DELETE", "OPTIONS",
                                "TRACE", "CONNECT"};
    string version_tag = "HTTP/";

    function automatic bit white_space(input logic [7:0] c);
        return (c == " ") || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Returns the hex digit value, or 16 when the byte is not a hex digit.
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return 16;
    endfunction

    function automatic int unsigned add_decimal(input int unsigned v, input logic [7:0] c);
        int unsigned cap;
        cap = (1 << hrsp_pkg::VERSION_BITS) - 1;
        v = v * 10 + 32'(c - "0");
        return (v > cap) ? cap : v;
    endfunction

    function void put_token_byte(input logic [7:0] b, input logic [2:0] cls);
        sh_out.token_class = cls;
        sh_out.out_byte    = b;
        sh_out.byte_valid  = 1'b1;
        sh_out.token_start = !sh_open;
        sh_open            = 1'b1;
    endfunction

    // A token can only close when no escape is half way through.
    function void end_token(input logic [2:0] cls);
        if (sh_pct != hrsp_pkg::PCT_IDLE) begin
            sh_phase = hrsp_pkg::PH_ERROR;
            return;
        end
        if (sh_open) begin
            sh_out.token_end   = 1'b1;
            sh_out.token_class = cls;
        end
        sh_open = 1'b0;
    endfunction

    function void query_char(input logic [7:0] c, input logic [2:0] cls);
        int h;
        if (c == 8'd0) begin
            sh_phase = hrsp_pkg::PH_ERROR;
            return;
        end
        if (sh_pct == hrsp_pkg::PCT_IDLE) begin
            if (c == "%") sh_pct = hrsp_pkg::PCT_HIGH;
            else put_token_byte(c, cls);
            return;
        end
        h = hex_digit(c);
        if (h > 15) begin
            sh_phase = hrsp_pkg::PH_ERROR;
        end else if (sh_pct == hrsp_pkg::PCT_HIGH) begin
            sh_nibble = h[3:0];
            sh_pct    = hrsp_pkg::PCT_LOW;
        end else begin
            put_token_byte({sh_nibble, h[3:0]}, cls);
            sh_pct = hrsp_pkg::PCT_IDLE;
        end
    endfunction

    function void parse_char(input logic [7:0] c);
        logic [2:0]       cls;
        hrsp_pkg::t_phase nxt;
        case (sh_phase)
            hrsp_pkg::PH_METHOD_FIRST: begin
                sh_pos   = 3'd1;
                sh_phase = hrsp_pkg::PH_METHOD_REST;
                case (c)
                    "H": sh_cand = 3'd0;
                    "G": sh_cand = 3'd1;
                    "P": sh_phase = hrsp_pkg::PH_METHOD_P;
                    "D": sh_cand = 3'd4;
                    "O": sh_cand = 3'd5;
                    "T": sh_cand = 3'd6;
                    "C": sh_cand = 3'd7;
                    default: sh_phase = hrsp_pkg::PH_ERROR;
                endcase
            end
            hrsp_pkg::PH_METHOD_P: begin
                if (c == "O" || c == "U") begin
                    sh_cand  = (c == "O") ? 3'd2 : 3'd3;
                    sh_pos   = 3'd2;
                    sh_phase = (method_names[sh_cand].len() <= 2) ? hrsp_pkg::PH_URI_WS :
                                                                   hrsp_pkg::PH_METHOD_REST;
                end else begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end
            end
            hrsp_pkg::PH_METHOD_REST: begin
                if (c != method_names[sh_cand][sh_pos]) begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end else begin
                    sh_pos = sh_pos + 3'd1;
                    if (sh_pos >= method_names[sh_cand].len()) sh_phase = hrsp_pkg::PH_URI_WS;
                end
            end
            hrsp_pkg::PH_URI_WS: begin
                if (white_space(c)) begin
                end else if (c == "?") begin
                    sh_phase = hrsp_pkg::PH_QKEY;
                end else if (c == 8'd0) begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end else begin
                    sh_phase = hrsp_pkg::PH_PATH;
                    put_token_byte(c, hrsp_pkg::CLS_PATH);
                end
            end
            hrsp_pkg::PH_PATH: begin
                if (c == "?" || c == " ") begin
                    end_token(hrsp_pkg::CLS_PATH);
                    if (sh_phase != hrsp_pkg::PH_ERROR)
                        sh_phase = (c == "?") ? hrsp_pkg::PH_QKEY : hrsp_pkg::PH_VER_WS;
                end else if (c == 8'd0) begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end else begin
                    put_token_byte(c, hrsp_pkg::CLS_PATH);
                end
            end
            hrsp_pkg::PH_QKEY, hrsp_pkg::PH_QVAL: begin
                cls = (sh_phase == hrsp_pkg::PH_QKEY) ? hrsp_pkg::CLS_QKEY : hrsp_pkg::CLS_QVAL;
                nxt = hrsp_pkg::PH_ERROR;
                if (c == "&") nxt = hrsp_pkg::PH_QKEY;
                else if (c == " ") nxt = hrsp_pkg::PH_VER_WS;
                else if (c == "=" && cls == hrsp_pkg::CLS_QKEY) nxt = hrsp_pkg::PH_QVAL;
                if (nxt != hrsp_pkg::PH_ERROR) begin
                    end_token(cls);
                    if (sh_phase != hrsp_pkg::PH_ERROR) sh_phase = nxt;
                end else begin
                    query_char(c, cls);
                end
            end
            hrsp_pkg::PH_VER_WS: begin
                if (white_space(c)) begin
                end else if (c != "H") begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end else begin
                    sh_pos   = 3'd1;
                    sh_phase = hrsp_pkg::PH_VER_LIT;
                end
            end
            hrsp_pkg::PH_VER_LIT: begin
                if (c != version_tag[sh_pos]) begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end else begin
                    sh_pos = sh_pos + 3'd1;
                    if (sh_pos >= 3'd5) begin
                        sh_phase  = hrsp_pkg::PH_MAJOR;
                        sh_digits = 1'b0;
                    end
                end
            end
            hrsp_pkg::PH_MAJOR: begin
                if (c >= "0" && c <= "9") begin
                    sh_major  = add_decimal(sh_major, c);
                    sh_digits = 1'b1;
                end else if (c == "." && sh_digits) begin
                    sh_phase  = hrsp_pkg::PH_MINOR;
                    sh_digits = 1'b0;
                end else begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end
            end
            hrsp_pkg::PH_MINOR: begin
                if (c >= "0" && c <= "9") begin
                    sh_minor  = add_decimal(sh_minor, c);
                    sh_digits = 1'b1;
                end else if (c == 8'h0D && sh_digits) begin
                    sh_phase = hrsp_pkg::PH_REQ_LF;
                end else begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end
            end
            hrsp_pkg::PH_REQ_LF, hrsp_pkg::PH_HDR_LF: begin
                sh_phase = (c == 8'h0A) ? hrsp_pkg::PH_HDR_START : hrsp_pkg::PH_ERROR;
            end
            hrsp_pkg::PH_HDR_START: begin
                if (c == 8'h0D) sh_phase = hrsp_pkg::PH_FINAL_LF;
                else if (c == ":" || c == " " || c == 8'd0) sh_phase = hrsp_pkg::PH_ERROR;
                else begin
                    sh_phase = hrsp_pkg::PH_HDR_NAME;
                    put_token_byte(c, hrsp_pkg::CLS_HNAME);
                end
            end
            hrsp_pkg::PH_HDR_NAME: begin
                if (c == ":") begin
                    end_token(hrsp_pkg::CLS_HNAME);
                    sh_phase = hrsp_pkg::PH_HDR_VALSP;
                end else if (c == " " || c == 8'h0D) begin
                    end_token(hrsp_pkg::CLS_HNAME);
                    sh_phase = hrsp_pkg::PH_HDR_COLONWS;
                end else if (c == 8'd0) begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end else begin
                    put_token_byte(c, hrsp_pkg::CLS_HNAME);
                end
            end
            hrsp_pkg::PH_HDR_COLONWS: begin
                if (c == ":") sh_phase = hrsp_pkg::PH_HDR_VALSP;
                else if (!white_space(c)) sh_phase = hrsp_pkg::PH_ERROR;
            end
            hrsp_pkg::PH_HDR_VALSP: begin
                if (c == " ") begin
                end else if (c == 8'h0D) begin
                    sh_phase = hrsp_pkg::PH_HDR_LF;
                end else if (c == 8'd0) begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end else begin
                    sh_phase = hrsp_pkg::PH_HDR_VAL;
                    put_token_byte(c, hrsp_pkg::CLS_HVAL);
                end
            end
            hrsp_pkg::PH_HDR_VAL: begin
                if (c == 8'h0D) begin
                    end_token(hrsp_pkg::CLS_HVAL);
                    sh_phase = hrsp_pkg::PH_HDR_LF;
                end else if (c == 8'd0) begin
                    sh_phase = hrsp_pkg::PH_ERROR;
                end else begin
                    put_token_byte(c, hrsp_pkg::CLS_HVAL);
                end
            end
            hrsp_pkg::PH_FINAL_LF: begin
                sh_phase = (c == 8'h0A) ? hrsp_pkg::PH_ACCEPT : hrsp_pkg::PH_ERROR;
            end
            default: begin
            end
        endcase
    endfunction

    // Advances the shadow parser by one input transaction and returns the
    // result transaction that the block must produce for it.
    function hrsp_pkg::t_result parse_transaction(input logic [7:0] c, input logic eoi);
        sh_out = '0;
        if (sh_phase != hrsp_pkg::PH_ACCEPT && sh_phase != hrsp_pkg::PH_ERROR) begin
            if (eoi) sh_phase = hrsp_pkg::PH_ERROR;
            else parse_char(c);
        end
        // A failed request reports no token activity at all.
        if (sh_phase == hrsp_pkg::PH_ERROR) begin
            sh_out.token_class = hrsp_pkg::CLS_NONE;
            sh_out.out_byte    = 8'd0;
            sh_out.byte_valid  = 1'b0;
            sh_out.token_start = 1'b0;
            sh_out.token_end   = 1'b0;
        end
        sh_out.method_code   = sh_cand;
        sh_out.version_major = sh_major[9:0];
        sh_out.version_minor = sh_minor[9:0];
        sh_out.parse_status  = (sh_phase == hrsp_pkg::PH_ACCEPT) ? hrsp_pkg::ST_ACCEPT :
                               (sh_phase == hrsp_pkg::PH_ERROR) ? hrsp_pkg::ST_ERROR :
                                                                  hrsp_pkg::ST_BUSY;
        return sh_out;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ---------------------------------------------------------------------
    // Request under test. Only one reset happens, so the whole run is one
    // long request: a hand-built opening (method, white space skip, path with
    // a high byte, percent escapes including one that decodes to zero, an
    // empty key), then random version digits and header lines, the blank line
    // that accepts it, and a tail of bytes that must be ignored.
    // ---------------------------------------------------------------------
    string directed_text = "PUT \t/\377?%4a=%00&&k HTTP/";

    logic [7:0] request_bytes[$];
    logic       request_eoi[$];
    int         directed_rows;

    // Random byte in 1..255 that is not one of the excluded delimiters.
    function automatic logic [7:0] token_char(input bit header_name);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == 8'h0D || (header_name && (b == ":" || b == " ")));
        return b;
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic eoi);
        request_bytes.push_back(b);
        request_eoi.push_back(eoi);
    endfunction

    function automatic void add_digits();
        int n;
        // Long digit runs drive the version into saturation.
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 2);
        repeat (n) add_byte(8'($urandom_range("0", "9")), 1'b0);
    endfunction

    function automatic void build_request();
        int n;
        for (int k = 0; k < directed_text.len(); k++) add_byte(directed_text[k], 1'b0);
        directed_rows = request_bytes.size();
        add_digits();
        add_byte(".", 1'b0);
        add_digits();
        add_byte(8'h0D, 1'b0);
        add_byte(8'h0A, 1'b0);
        while (request_bytes.size() < 720) begin
            n = $urandom_range(1, 8);
            repeat (n) add_byte(token_char(1'b1), 1'b0);
            // Name ends at the colon, at a space, or at a CR followed by
            // white space before the colon.
            case ($urandom_range(0, 3))
                0: add_byte(" ", 1'b0);
                1: begin
                    add_byte(8'h0D, 1'b0);
                    add_byte(8'h09, 1'b0);
                    add_byte(8'h0A, 1'b0);
                end
                default: begin
                end
            endcase
            add_byte(":", 1'b0);
            repeat ($urandom_range(0, 3)) add_byte(" ", 1'b0);
            n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
            repeat (n) add_byte(token_char(1'b0), 1'b0);
            add_byte(8'h0D, 1'b0);
            add_byte(8'h0A, 1'b0);
        end
        add_byte(8'h0D, 1'b0);
        add_byte(8'h0A, 1'b0);
        // After acceptance everything is ignored, end of input included.
        add_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (6) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    // ---------------------------------------------------------------------
    // Sender: drives at the falling edge, sees acceptance at the rising edge.
    // ---------------------------------------------------------------------
    initial begin
        t_pending p;
        int       gap;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data_byte    = 8'd0;
        i_end_of_input = 1'b0;
        error_count    = 0;
        stim_done      = 1'b0;
        sh_phase       = hrsp_pkg::PH_METHOD_FIRST;
        sh_cand        = 3'd0;
        sh_pos         = 3'd0;
        sh_pct         = hrsp_pkg::PCT_IDLE;
        sh_nibble      = 4'd0;
        sh_major       = 0;
        sh_minor       = 0;
        sh_digits      = 1'b0;
        sh_open        = 1'b0;
        build_request();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (request_bytes[k]) begin
            gap = idle_cycles();
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_valid        = 1'b1;
            i_data_byte    = request_bytes[k];
            i_end_of_input = request_eoi[k];
            do @(posedge i_clk); while (!o_ready);
            p.res          = parse_transaction(request_bytes[k], request_eoi[k]);
            p.typed        = (k < directed_rows);
            p.typed_status = hrsp_pkg::ST_BUSY;
            pending_results.push_back(p);
            @(negedge i_clk);
        end
        i_valid   = 1'b0;
        stim_done = 1'b1;
    end

    // ---------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off partway through so the
    // output and skid registers fill and the input side has to stall.
    // ---------------------------------------------------------------------
    initial begin
        int gap;
        int held;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (results_seen == 300) begin
                i_ready = 1'b0;
                held    = 0;
                while (held < 200) begin
                    @(negedge i_clk);
                    held++;
                end
                i_ready = 1'b1;
                @(negedge i_clk);
            end
            gap = ($urandom_range(0, 1) == 0) ? 0 : idle_cycles();
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
        end
    end

    // Each accepted result transaction is checked field by field against the
    // oldest pending one.
    always @(posedge i_clk) begin
        t_pending p;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transaction", 1, 0);
            end else begin
                p = pending_results.pop_front();
                if (o_token_class !== p.res.token_class)
                    report_mismatch("token_class", int'(o_token_class),
                                    int'(p.res.token_class));
                if (o_out_byte !== p.res.out_byte)
                    report_mismatch("out_byte", int'(o_out_byte), int'(p.res.out_byte));
                if (o_byte_valid !== p.res.byte_valid)
                    report_mismatch("byte_valid", int'(o_byte_valid), int'(p.res.byte_valid));
                if (o_token_start !== p.res.token_start)
                    report_mismatch("token_start", int'(o_token_start),
                                    int'(p.res.token_start));
                if (o_token_end !== p.res.token_end)
                    report_mismatch("token_end", int'(o_token_end), int'(p.res.token_end));
                if (o_method_code !== p.res.method_code)
                    report_mismatch("method_code", int'(o_method_code),
                                    int'(p.res.method_code));
                if (o_version_major !== p.res.version_major)
                    report_mismatch("version_major", int'(o_version_major),
                                    int'(p.res.version_major));
                if (o_version_minor !== p.res.version_minor)
                    report_mismatch("version_minor", int'(o_version_minor),
                                    int'(p.res.version_minor));
                if (o_parse_status !== p.res.parse_status)
                    report_mismatch("parse_status", int'(o_parse_status),
                                    int'(p.res.parse_status));
                if (p.typed && o_parse_status !== p.typed_status)
                    report_mismatch("opening status", int'(o_parse_status),
                                    int'(p.typed_status));
            end
            results_seen++;
        end
    end

    initial results_seen = 0;

    // Normal end: all transactions sent, every result back, then a short drain
    // so that a stray extra result would still be caught.
    initial begin
        wait (stim_done);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hrsp_pkg.sv
rtl/http_request_stream_parser_unit.sv
dv/http_request_stream_parser_unit_tb.sv
